>>> rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// shared types and codes for the dependency task dispatcher
// ----------------------------------------------------------------------------
package dtd_pkg;

    localparam int MASK_W  = 64;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int OUTC_W  = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET  = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

    // task outcomes, every other code means success stop
    localparam logic [OUTC_W-1:0] OUTC_FAIL = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_CONT = 2'd1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DISPATCH = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd1;
    localparam logic [STAT_W-1:0] ST_COMPLETE = 3'd2;
    localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_STUCK    = 3'd4;
    localparam logic [STAT_W-1:0] ST_ACK      = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRIME,
        S_SCAN,
        S_EMIT
    } t_state;

    // verdict on one table entry against the finished mask
    typedef struct packed {
        logic undone;
        logic ready;
    } t_eval;

endpackage

>>> rtl/dtd_ram.sv
// ----------------------------------------------------------------------------
// dtd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dtd_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dtd_eval.sv
// ----------------------------------------------------------------------------
// dtd_eval
// checks one table entry: not yet finished, and all dependencies finished
// ----------------------------------------------------------------------------
module dtd_eval (
    input  logic [dtd_pkg::MASK_W-1:0] i_id_mask,
    input  logic [dtd_pkg::MASK_W-1:0] i_dep_mask,
    input  logic [dtd_pkg::MASK_W-1:0] i_finished,
    output dtd_pkg::t_eval             o_eval
);
    import dtd_pkg::*;

    always_comb begin
        o_eval.undone = ((i_id_mask & i_finished) == '0);
        o_eval.ready  = ((i_dep_mask & i_finished) == i_dep_mask);
    end

endmodule

>>> rtl/dependency_task_dispatcher.sv
// ----------------------------------------------------------------------------
// dependency_task_dispatcher
// task table with dependency masks, scanned one entry per cycle from memory
// ----------------------------------------------------------------------------
// load, reset and most outcome reports answer in the cycle after acceptance
// a scan examines k entries (k up to task count, 64 max) in order:
//   a read-prime step, one entry per cycle from the table ram, a result step
// throughput: one transaction at a time; input stalls while a scan runs or a result is held
// reset: synchronous active low, clears control state and the task count;
//   the table ram is not cleared and must be loaded before use
module dependency_task_dispatcher #(
    parameter int MAX_TASKS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write (task count)
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dtd_pkg::CNT_W-1:0]  i_cfg_data,
    // input transactions
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [dtd_pkg::OP_W-1:0]   i_opcode,
    input  logic [dtd_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [dtd_pkg::MASK_W-1:0] i_entry_id_mask,
    input  logic [dtd_pkg::MASK_W-1:0] i_entry_dep_mask,
    input  logic [dtd_pkg::OUTC_W-1:0] i_task_outcome,
    // result transactions
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [dtd_pkg::STAT_W-1:0] o_status,
    output logic [dtd_pkg::IDX_W-1:0]  o_task_index
);
    import dtd_pkg::*;

    localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_TASKS);

    // control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_task_count, n_task_count;
    logic [MASK_W-1:0]     r_finished, n_finished;
    logic [CNT_W-1:0]      r_left, n_left;
    logic [CNT_W-1:0]      r_first, n_first;
    logic [CNT_W-1:0]      r_scan_pos, n_scan_pos;
    logic [CNT_W-1:0]      r_skip, n_skip;
    logic                  r_awaiting, n_awaiting;
    // id mask of the dispatched task, folded into finished on success
    logic [MASK_W-1:0]     r_disp_id, n_disp_id;
    // result waiting for the output register
    logic [STAT_W-1:0]     r_res_status, n_res_status;
    logic [IDX_W-1:0]      r_res_index, n_res_index;
    // output register
    logic                  r_out_valid, n_out_valid;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [IDX_W-1:0]      r_task_index, n_task_index;

    // table ram: {id mask, dep mask}
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [2*MASK_W-1:0]   ram_rdata;
    logic [MASK_W-1:0]     rd_id;
    logic [MASK_W-1:0]     rd_dep;
    t_eval                 eval;

    logic                  out_free;
    logic                  in_accept;
    logic [CNT_W-1:0]      bound;
    logic [CNT_W-1:0]      left_dec;
    logic [CNT_W-1:0]      next_pos;

    assign bound     = (r_task_count > MAX_N) ? MAX_N : r_task_count;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept = i_in_valid && !o_in_stall;
    assign left_dec  = (r_left != '0) ? r_left - 1'b1 : r_left;
    assign next_pos  = r_scan_pos + 1'b1;
    assign o_cfg_ready = 1'b1;

    // loads happen only in idle, so a write never meets a scan read
    assign ram_we = in_accept && (i_opcode == OP_LOAD)
                    && ({1'b0, i_entry_index} < MAX_N);

    assign ram_raddr = (r_state == S_SCAN) ? next_pos[ADDR_W-1:0]
                                           : r_scan_pos[ADDR_W-1:0];

    dtd_ram #(
        .WIDTH (2*MASK_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata ({i_entry_id_mask, i_entry_dep_mask}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id  = ram_rdata[2*MASK_W-1:MASK_W];
    assign rd_dep = ram_rdata[MASK_W-1:0];

    dtd_eval u_eval (
        .i_id_mask  (rd_id),
        .i_dep_mask (rd_dep),
        .i_finished (r_finished),
        .o_eval     (eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= '0;
            r_finished   <= '0;
            r_left       <= '0;
            r_first      <= '0;
            r_scan_pos   <= '0;
            r_skip       <= '0;
            r_awaiting   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_task_count <= n_task_count;
            r_finished   <= n_finished;
            r_left       <= n_left;
            r_first      <= n_first;
            r_scan_pos   <= n_scan_pos;
            r_skip       <= n_skip;
            r_awaiting   <= n_awaiting;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_disp_id    <= n_disp_id;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_status     <= n_status;
        r_task_index <= n_task_index;
    end

    always_comb begin
        logic [CNT_W-1:0] start_pos;
        logic             do_start;
        logic             do_emit;
        logic [STAT_W-1:0] emit_status;

        n_state      = r_state;
        n_task_count = r_task_count;
        n_finished   = r_finished;
        n_left       = r_left;
        n_first      = r_first;
        n_scan_pos   = r_scan_pos;
        n_skip       = r_skip;
        n_awaiting   = r_awaiting;
        n_disp_id    = r_disp_id;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_task_index = r_task_index;

        start_pos   = r_scan_pos;
        do_start    = 1'b0;
        do_emit     = 1'b0;
        emit_status = ST_ACK;

        if (i_cfg_valid) begin
            n_task_count = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_opcode)
                        OP_LOAD: begin
                            // a reload of the dispatched slot changes what success marks
                            if (i_entry_index == r_scan_pos[IDX_W-1:0]) begin
                                n_disp_id = i_entry_id_mask;
                            end
                            do_emit = 1'b1;
                        end
                        OP_RESET: begin
                            n_finished = '0;
                            n_left     = bound;
                            n_first    = '0;
                            n_scan_pos = '0;
                            n_skip     = '0;
                            n_awaiting = 1'b0;
                            do_emit    = 1'b1;
                        end
                        OP_START: begin
                            n_awaiting = 1'b0;
                            if (r_left == '0) begin
                                do_emit     = 1'b1;
                                emit_status = ST_NOTHING;
                            end else begin
                                n_skip    = '0;
                                start_pos = r_first;
                                do_start  = 1'b1;
                            end
                        end
                        OP_REPORT: begin
                            if (!r_awaiting) begin
                                do_emit = 1'b1;
                            end else if (i_task_outcome == OUTC_FAIL) begin
                                // skip this task and resume behind it
                                if (r_skip != CNT_MAX) begin
                                    n_skip = r_skip + 1'b1;
                                end
                                start_pos = next_pos;
                                do_start  = 1'b1;
                            end else begin
                                n_awaiting = 1'b0;
                                n_left     = left_dec;
                                n_finished = r_finished | r_disp_id;
                                if (r_skip == '0 && r_first != CNT_MAX) begin
                                    n_first = r_first + 1'b1;
                                end
                                if (left_dec == '0) begin
                                    do_emit     = 1'b1;
                                    emit_status = ST_COMPLETE;
                                end else if (i_task_outcome == OUTC_CONT) begin
                                    start_pos = next_pos;
                                    do_start  = 1'b1;
                                end else begin
                                    do_emit     = 1'b1;
                                    emit_status = ST_RUNNING;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (do_start) begin
                        n_scan_pos = start_pos;
                        if (start_pos >= bound) begin
                            // nothing left to look at: stuck at once
                            n_awaiting  = 1'b0;
                            do_emit     = 1'b1;
                            emit_status = ST_STUCK;
                        end else begin
                            n_state = S_PRIME;
                        end
                    end

                    if (do_emit) begin
                        n_out_valid  = 1'b1;
                        n_status     = emit_status;
                        n_task_index = '0;
                    end
                end
            end

            S_PRIME: begin
                // first read issued at scan_pos, data arrives in scan
                n_state = S_SCAN;
            end

            S_SCAN: begin
                // ram data belongs to scan_pos; next entry already requested
                if (eval.undone && eval.ready) begin
                    n_disp_id    = rd_id;
                    n_awaiting   = 1'b1;
                    n_res_status = ST_DISPATCH;
                    n_res_index  = r_scan_pos[IDX_W-1:0];
                    n_state      = S_EMIT;
                end else begin
                    if (eval.undone) begin
                        if (r_skip != CNT_MAX) begin
                            n_skip = r_skip + 1'b1;
                        end
                    end else if (r_skip == '0 && r_first != CNT_MAX) begin
                        // finished task at the head moves the first pending mark
                        n_first = r_first + 1'b1;
                    end
                    n_scan_pos = next_pos;
                    if (next_pos >= bound) begin
                        n_awaiting   = 1'b0;
                        n_res_status = ST_STUCK;
                        n_res_index  = '0;
                        n_state      = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = r_res_status;
                    n_task_index = r_res_index;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_task_index = r_task_index;

endmodule

>>> rtl/dtd_checker.sv
// ----------------------------------------------------------------------------
// dtd_checker
// port-level checks for the dependency task dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module dtd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [dtd_pkg::OP_W-1:0]   i_opcode,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [dtd_pkg::STAT_W-1:0] o_status,
    input logic [dtd_pkg::IDX_W-1:0]  o_task_index
);
    import dtd_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_task_index))
        else $error("stalled result changed");

    // task index is zero except on dispatch
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DISPATCH) |-> (o_task_index == '0))
        else $error("task index set without dispatch");

    // load and reset answer acknowledged in the next cycle
    a_ack_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_opcode == OP_LOAD || i_opcode == OP_RESET) |=>
            o_out_valid && (o_status == ST_ACK))
        else $error("missing acknowledge");

    // one transaction at a time: after acceptance either a result shows or input stalls
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid || o_in_stall)
        else $error("input taken again before result");

endmodule

bind dependency_task_dispatcher dtd_checker u_dtd_checker (.*);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression bench for the dependency task dispatcher: an internal predictor
// tracks the task table and scan state, and every result transaction is
// checked against it while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb;
    import dtd_pkg::*;

    localparam int TASKS       = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 930;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_TAIL  = 80;

    // outcome codes with no name in the package
    localparam logic [OUTC_W-1:0] OUTC_STOP     = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_CODE_THREE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  task_index;
    } t_dispatch_result;

    // predictor of the dispatcher plus the queue of results still due
    class dispatch_scoreboard;
        logic [MASK_W-1:0] id_tbl [TASKS];
        logic [MASK_W-1:0] dep_tbl [TASKS];
        logic [MASK_W-1:0] done_mask;
        logic [CNT_W-1:0]  task_cnt;
        logic [CNT_W-1:0]  left_cnt;
        logic [CNT_W-1:0]  head_idx;
        logic [CNT_W-1:0]  scan_idx;
        logic [CNT_W-1:0]  skip_cnt;
        bit                waiting;
        t_dispatch_result  due_q [$];
        int                errors;
        int                checked;
        int                n_dispatch;
        int                n_stuck;
        int                n_complete;

        function new();
            foreach (id_tbl[k]) begin
                id_tbl[k]  = '0;
                dep_tbl[k] = '0;
            end
            done_mask  = '0;
            task_cnt   = '0;
            left_cnt   = '0;
            head_idx   = '0;
            scan_idx   = '0;
            skip_cnt   = '0;
            waiting    = 1'b0;
            errors     = 0;
            checked    = 0;
            n_dispatch = 0;
            n_stuck    = 0;
            n_complete = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            task_cnt = v;
        endfunction

        function int scan_limit();
            return (int'(task_cnt) > TASKS) ? TASKS : int'(task_cnt);
        endfunction

        function void push_due(logic [STAT_W-1:0] st, logic [IDX_W-1:0] ix);
            t_dispatch_result r;
            r.status     = st;
            r.task_index = ix;
            due_q.push_back(r);
        endfunction

        // walk from scan_idx to the first undone task whose deps are all done
        function void scan_ready();
            int n;
            int i;
            n = scan_limit();
            for (i = int'(scan_idx); i < n; i++) begin
                if ((id_tbl[i] & done_mask) == '0) begin
                    if ((dep_tbl[i] & done_mask) == dep_tbl[i]) begin
                        scan_idx = CNT_W'(i);
                        waiting  = 1'b1;
                        push_due(ST_DISPATCH, IDX_W'(i));
                        return;
                    end
                    if (skip_cnt != CNT_MAX) skip_cnt++;
                end else if (skip_cnt == '0) begin
                    // finished tasks at the head move the next pass start down
                    if (head_idx != CNT_MAX) head_idx++;
                end
            end
            scan_idx = CNT_W'(i);
            waiting  = 1'b0;
            push_due(ST_STUCK, '0);
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] slot,
                                logic [MASK_W-1:0] id_m, logic [MASK_W-1:0] dep_m,
                                logic [OUTC_W-1:0] outc);
            case (op)
                OP_LOAD: begin
                    id_tbl[slot]  = id_m;
                    dep_tbl[slot] = dep_m;
                    push_due(ST_ACK, '0);
                end
                OP_RESET: begin
                    done_mask = '0;
                    left_cnt  = CNT_W'(scan_limit());
                    head_idx  = '0;
                    scan_idx  = '0;
                    skip_cnt  = '0;
                    waiting   = 1'b0;
                    push_due(ST_ACK, '0);
                end
                OP_START: begin
                    // a pending dispatch is dropped by a new pass
                    waiting = 1'b0;
                    if (left_cnt == '0) begin
                        push_due(ST_NOTHING, '0);
                    end else begin
                        scan_idx = head_idx;
                        skip_cnt = '0;
                        scan_ready();
                    end
                end
                default: begin
                    if (!waiting) begin
                        push_due(ST_ACK, '0);
                    end else if (outc == OUTC_FAIL) begin
                        if (skip_cnt != CNT_MAX) skip_cnt++;
                        scan_idx++;
                        scan_ready();
                    end else begin
                        waiting = 1'b0;
                        if (left_cnt != '0) left_cnt--;
                        done_mask |= id_tbl[scan_idx[IDX_W-1:0]];
                        if (skip_cnt == '0 && head_idx != CNT_MAX) head_idx++;
                        if (left_cnt == '0) begin
                            push_due(ST_COMPLETE, '0);
                        end else if (outc == OUTC_CONT) begin
                            scan_idx++;
                            scan_ready();
                        end else begin
                            push_due(ST_RUNNING, '0);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [IDX_W-1:0] ix);
            t_dispatch_result want;
            if (due_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, status %0d index %0d",
                         $time, st, ix);
                return;
            end
            want = due_q.pop_front();
            checked++;
            if (st !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, st);
            end
            if (ix !== want.task_index) begin
                errors++;
                $display("%0t: task index mismatch, expected %0d actual %0d",
                         $time, want.task_index, ix);
            end
            case (want.status)
                ST_DISPATCH: n_dispatch++;
                ST_STUCK:    n_stuck++;
                ST_COMPLETE: n_complete++;
                default: ;
            endcase
        endfunction
    endclass

    // block ports, all inputs known from time zero
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data       = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_opcode         = OP_LOAD;
    logic [IDX_W-1:0]    i_entry_index    = '0;
    logic [MASK_W-1:0]   i_entry_id_mask  = '0;
    logic [MASK_W-1:0]   i_entry_dep_mask = '0;
    logic [OUTC_W-1:0]   i_task_outcome   = OUTC_FAIL;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [IDX_W-1:0]    o_task_index;

    dispatch_scoreboard sb;

    // sender state, owned by the stimulus process
    int          item_cnt   = 0;
    int          burst_left = 0;
    bit          tx_gappy   = 1'b1;
    int          cfg_writes = 0;
    int          hold_reqs  = 0;

    // receiver state, owned by the receiver process
    int          hold_taken = 0;
    int          hold_cnt   = 0;
    int          rx_mode    = 0;
    int          rx_left    = 0;
    int unsigned cyc        = 0;

    dependency_task_dispatcher #(
        .MAX_TASKS (TASKS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_entry_id_mask  (i_entry_id_mask),
        .i_entry_dep_mask (i_entry_dep_mask),
        .i_task_outcome   (i_task_outcome),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_task_index     (o_task_index)
    );

    always #1 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cyc, sb.due_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: checks each result transaction, then picks the next stall
    // value from a mode that it redraws at random; a hold-off request from
    // the stimulus side holds it stalled solid until its hold count runs out
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_task_index);
        end
        if (hold_reqs != hold_taken) begin
            hold_taken  <= hold_reqs;
            hold_cnt    <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= ((cyc % 5) < 2);
            endcase
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(50, 400);
            end else begin
                rx_left <= rx_left - 1;
            end
        end
    end

    function automatic logic [MASK_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [OUTC_W-1:0] pick_outcome();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return OUTC_FAIL;
        if (r < 60) return OUTC_CONT;
        if (r < 88) return OUTC_STOP;
        return OUTC_CODE_THREE;
    endfunction

    // mostly small lists, now and then the full table or an oversized count
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'(TASKS);
            2:       return CNT_W'($urandom_range(TASKS + 1, 127));
            3, 4:    return CNT_W'($urandom_range(17, TASKS - 1));
            default: return CNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    // one input transaction; called and returning at a rising edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] slot,
                             input logic [MASK_W-1:0] id_m, input logic [MASK_W-1:0] dep_m,
                             input logic [OUTC_W-1:0] outc);
        if (tx_gappy && burst_left <= 0) begin
            // gap between bursts
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_entry_index    <= slot;
        i_entry_id_mask  <= id_m;
        i_entry_dep_mask <= dep_m;
        i_task_outcome   <= outc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(op, slot, id_m, dep_m, outc);
        burst_left--;
        item_cnt++;
    endtask

    // same, with a random slot and random masks
    task automatic send_op(input logic [OP_W-1:0] op, input logic [OUTC_W-1:0] outc);
        send_item(op, IDX_W'($urandom_range(0, TASKS - 1)), rnd64(), rnd64(), outc);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // task count register, written only with the block idle
    task automatic write_count(input logic [CNT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_count(v);
        cfg_writes++;
    endtask

    // load slots 0..m-1 as a dependency graph: mostly one identity bit per
    // task and deps on earlier tasks, with some forward deps (out of order
    // readiness, possible deadlock), shared or empty identities and full masks
    task automatic load_graph(input int m);
        logic [MASK_W-1:0] earlier_ids;
        logic [MASK_W-1:0] id_m;
        logic [MASK_W-1:0] dep_m;
        int                s;
        int                r;
        earlier_ids = '0;
        for (s = 0; s < m; s++) begin
            r = $urandom_range(0, 19);
            if (r == 0)      id_m = rnd64();
            else if (r == 1) id_m = '0;
            else             id_m = 64'd1 << s;
            r = $urandom_range(0, 19);
            if (r == 0)      dep_m = rnd64();
            else if (r == 1) dep_m = '1;
            else if (r < 6)  dep_m = rnd64() & rnd64() & ~earlier_ids & ~id_m;
            else             dep_m = rnd64() & rnd64() & earlier_ids;
            send_item(OP_LOAD, IDX_W'(s), id_m, dep_m, OUTC_W'($urandom_range(0, 3)));
            earlier_ids |= id_m;
        end
    endtask

    // one list run: restart the state, then keep passing and answering
    // dispatches until the list completes or the budget runs out; about one
    // transaction in twelve is noise
    task automatic run_session(input logic [CNT_W-1:0] n, input bit reload);
        int m;
        int budget;
        m = (int'(n) > TASKS) ? TASKS : int'(n);
        if (reload) load_graph(m);
        send_op(OP_RESET, pick_outcome());
        send_op(OP_START, pick_outcome());
        budget = 3 * m + 8;
        while (budget > 0 && (sb.waiting || sb.left_cnt != '0)) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0:       send_op(OP_REPORT, OUTC_W'($urandom_range(0, 3)));
                    1:       send_op(OP_START, pick_outcome());
                    2:       send_op(OP_LOAD, pick_outcome());
                    default: send_op(OP_RESET, pick_outcome());
                endcase
            end else if (sb.waiting) begin
                send_op(OP_REPORT, pick_outcome());
            end else begin
                send_op(OP_START, pick_outcome());
            end
            budget--;
        end
    endtask

    initial begin
        int               s;
        int               rnd_start;
        int               sess;
        logic [CNT_W-1:0] n;
        bit               reload;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // empty list: pass finds nothing, outcome with nothing dispatched
        send_op(OP_START, OUTC_FAIL);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_RESET, OUTC_FAIL);
        send_op(OP_START, OUTC_FAIL);

        // whole table as a chain, each task waiting on the one before
        for (s = 0; s < TASKS; s++) begin
            send_item(OP_LOAD, IDX_W'(s), 64'd1 << s, (s == 0) ? '0 : 64'd1 << (s - 1),
                      OUTC_W'($urandom_range(0, 3)));
        end

        // oversized count clamps to the table size
        write_count('1);
        send_op(OP_RESET, OUTC_FAIL);
        send_op(OP_START, OUTC_FAIL);           // dispatch head
        send_op(OP_REPORT, OUTC_FAIL);          // skip it, rest blocked: stuck
        send_op(OP_START, OUTC_FAIL);
        send_op(OP_REPORT, OUTC_CODE_THREE);    // code three acts as stop
        send_op(OP_START, OUTC_FAIL);
        send_op(OP_START, OUTC_FAIL);           // abandon the pending dispatch
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_REPORT, OUTC_STOP);

        // extreme masks mid-list: an identity of all ones, a dep of all ones
        send_item(OP_LOAD, 6'd5, '1, '0, OUTC_CONT);
        send_item(OP_LOAD, 6'd6, '0, '1, OUTC_FAIL);
        send_op(OP_START, OUTC_FAIL);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_REPORT, OUTC_STOP);

        // count shrunk to zero with tasks left: the scan has nothing to look at
        write_count('0);
        send_op(OP_START, OUTC_FAIL);

        // single task list runs to completion
        write_count(CNT_W'(1));
        send_op(OP_RESET, OUTC_FAIL);
        send_op(OP_START, OUTC_FAIL);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_REPORT, OUTC_CONT);
        send_op(OP_START, OUTC_FAIL);

        // --- random part ---
        rnd_start = item_cnt;
        sess      = 0;
        n         = CNT_W'(1);
        while (item_cnt - rnd_start < RANDOM_ITEMS) begin
            tx_gappy = ($urandom_range(0, 2) != 0);
            if (sess == 0 || $urandom_range(0, 1) == 0) begin
                n = pick_count();
                write_count(n);
                reload = 1'b1;
            end else begin
                reload = ($urandom_range(0, 2) == 0);
            end
            // receiver holds off while the sender keeps offering
            if (sess == 2 || sess == 9) hold_reqs <= hold_reqs + 1;
            run_session(n, reload);
            sess++;
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.due_q.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.due_q.size());
        end

        $display("ran %0d transactions over %0d list runs and %0d task count writes",
                 item_cnt, sess, cfg_writes);
        $display("checked %0d results: %0d dispatches, %0d stuck scans, %0d completions",
                 sb.checked, sb.n_dispatch, sb.n_stuck, sb.n_complete);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/dtd_pkg.sv
rtl/dtd_ram.sv
rtl/dtd_eval.sv
rtl/dependency_task_dispatcher.sv
rtl/dtd_checker.sv
test/tb.sv
